// ===== src/field_inverse_p25519_core_defines.svh =====
// Assertion macros for the GF(2^255-19) exponentiation core.
// Used by field_inverse_p25519_core; expects clk and rst_n in scope.
`ifndef FIELD_INVERSE_P25519_CORE_DEFINES_SVH
`define FIELD_INVERSE_P25519_CORE_DEFINES_SVH

`define FIP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define FIP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/fip_pkg.sv =====
// Types, constants and the exponent program of the GF(2^255-19) exponentiation core.
// Depends on nothing; used by fip_cell and field_inverse_p25519_core.
`timescale 1ns / 1ps
`default_nettype none

package fip_pkg;

    localparam int FIP_LIMBS = 16;
    localparam int FIP_CW    = 33;
    localparam int FIP_FW    = 23;
    localparam int FIP_FOLD  = 38;
    localparam int FIP_REGS  = 10;

    localparam logic [255:0] FIP_P =
        256'h7fffffffffffffff_ffffffffffffffff_ffffffffffffffff_ffffffffffffffed;

    localparam logic [3:0] R_Z    = 4'd0;
    localparam logic [3:0] R_Z2   = 4'd1;
    localparam logic [3:0] R_T    = 4'd2;
    localparam logic [3:0] R_Z9   = 4'd3;
    localparam logic [3:0] R_Z11  = 4'd4;
    localparam logic [3:0] R_A5   = 4'd5;
    localparam logic [3:0] R_A10  = 4'd6;
    localparam logic [3:0] R_A20  = 4'd7;
    localparam logic [3:0] R_A50  = 4'd8;
    localparam logic [3:0] R_A100 = 4'd9;

    localparam logic [4:0] PC_BRANCH   = 5'd19;
    localparam logic [4:0] PC_INV      = 5'd20;
    localparam logic [4:0] PC_INV_END  = 5'd21;
    localparam logic [4:0] PC_SQRT     = 5'd22;
    localparam logic [4:0] PC_SQRT_END = 5'd23;

    localparam logic OP_INVERSE = 1'b0;
    localparam logic OP_SQRT    = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [63:0] value_w3;
        logic [63:0] value_w2;
        logic [63:0] value_w1;
        logic [63:0] value_w0;
    } fip_in_t;

    typedef struct packed {
        logic [62:0] result_w3;
        logic [63:0] result_w2;
        logic [63:0] result_w1;
        logic [63:0] result_w0;
    } fip_out_t;

    typedef struct packed {
        logic clear;
        logic mul;
        logic norm;
    } fip_cell_ctl_t;

    typedef struct packed {
        logic [3:0] dst;
        logic [3:0] src_a;
        logic [3:0] src_b;
        logic [6:0] sq;
    } fip_step_t;

    // Each step multiplies src_a by src_b, squares the product sq more times
    // and stores it in dst.
    function automatic fip_step_t fip_step(input logic [4:0] pc);
        fip_step_t s;
        s = '0;
        unique case (pc)
            5'd0:  s = '{R_Z2,   R_Z,    R_Z,    7'd0};
            5'd1:  s = '{R_T,    R_Z2,   R_Z2,   7'd1};
            5'd2:  s = '{R_Z9,   R_T,    R_Z,    7'd0};
            5'd3:  s = '{R_Z11,  R_Z9,   R_Z2,   7'd0};
            5'd4:  s = '{R_T,    R_Z11,  R_Z11,  7'd0};
            5'd5:  s = '{R_A5,   R_T,    R_Z9,   7'd0};
            5'd6:  s = '{R_T,    R_A5,   R_A5,   7'd4};
            5'd7:  s = '{R_A10,  R_T,    R_A5,   7'd0};
            5'd8:  s = '{R_T,    R_A10,  R_A10,  7'd9};
            5'd9:  s = '{R_A20,  R_T,    R_A10,  7'd0};
            5'd10: s = '{R_T,    R_A20,  R_A20,  7'd19};
            5'd11: s = '{R_T,    R_T,    R_A20,  7'd0};
            5'd12: s = '{R_T,    R_T,    R_T,    7'd9};
            5'd13: s = '{R_A50,  R_T,    R_A10,  7'd0};
            5'd14: s = '{R_T,    R_A50,  R_A50,  7'd49};
            5'd15: s = '{R_A100, R_T,    R_A50,  7'd0};
            5'd16: s = '{R_T,    R_A100, R_A100, 7'd99};
            5'd17: s = '{R_T,    R_T,    R_A100, 7'd0};
            5'd18: s = '{R_T,    R_T,    R_T,    7'd49};
            5'd19: s = '{R_T,    R_T,    R_A50,  7'd0};
            5'd20: s = '{R_T,    R_T,    R_T,    7'd4};
            5'd21: s = '{R_T,    R_T,    R_Z11,  7'd0};
            5'd22: s = '{R_T,    R_T,    R_T,    7'd1};
            5'd23: s = '{R_T,    R_T,    R_Z,    7'd0};
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== src/fip_cell.sv =====
// One limb cell of the multiplier row: a 16x16 product plus neighbor terms.
// Depends on fip_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fip_cell
    import fip_pkg::*;
(
    input  wire logic                clk,
    input  wire fip_cell_ctl_t       ctl,
    input  wire logic [15:0]         a_limb,
    input  wire logic [15:0]         digit,
    input  wire logic [FIP_FW-1:0]   shift_lo,
    input  wire logic [FIP_FW-1:0]   shift_hi,
    input  wire logic [FIP_FW-1:0]   carry_in,
    output logic [15:0]              lo,
    output logic [FIP_CW-17:0]       hi
);

    logic [FIP_CW-1:0] w_reg;
    logic [31:0]       prod;
    logic [FIP_CW-1:0] mul_sum;
    logic [FIP_CW-1:0] norm_sum;

    assign prod     = a_limb * digit;
    assign mul_sum  = FIP_CW'(prod) + FIP_CW'(shift_lo) + FIP_CW'(shift_hi);
    assign norm_sum = FIP_CW'(w_reg[15:0]) + FIP_CW'(carry_in);

    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            w_reg <= '0;
        end
        else if (ctl.mul)
        begin
            w_reg <= mul_sum;
        end
        else if (ctl.norm)
        begin
            w_reg <= norm_sum;
        end
    end

    assign lo = w_reg[15:0];
    assign hi = w_reg[FIP_CW-1:16];

endmodule

`default_nettype wire

// ===== src/field_inverse_p25519_core.sv =====
// Each field multiplication runs in the row of sixteen limb cells, digit by
// digit, then settles carries until no cell holds a carry. One beat at a time;
// busy is high for the whole run. Reset clears control state only.
`timescale 1ns / 1ps
`default_nettype none
`include "field_inverse_p25519_core_defines.svh"

module field_inverse_p25519_core
    import fip_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire fip_in_t operand,
    output logic         busy,
    output logic         done,
    output fip_out_t     result
);

    typedef enum logic [2:0] {ST_IDLE, ST_LOAD, ST_MUL, ST_NORM, ST_SUB} state_t;

    state_t     state_reg, state_next;
    logic [4:0] pc_reg, pc_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [6:0] sq_reg, sq_next;
    logic       op_reg, op_next;
    logic       done_reg, done_next;

    logic [255:0] a_reg, b_reg, res_reg;
    logic [255:0] mem [FIP_REGS];

    fip_step_t     step;
    fip_cell_ctl_t ctl;
    logic          load_ops, reload_sq, write_back, take_res, sub_en, accept;

    logic [15:0]        cell_lo [FIP_LIMBS];
    logic [FIP_CW-17:0] cell_hi [FIP_LIMBS];
    logic [FIP_LIMBS-1:0] hi_nz;
    logic [255:0]       norm_val;
    logic [256:0]       diff;

    assign step   = fip_step(pc_reg);
    assign accept = start && !busy;

    for (genvar j = 0; j < FIP_LIMBS; j++)
    begin : g_cell
        logic [FIP_FW-1:0] s_lo, s_hi, c_in;
        if (j == 0)
        begin : g_first
            assign s_lo = FIP_FW'(cell_lo[FIP_LIMBS-1]) * FIP_FW'(FIP_FOLD);
            assign s_hi = FIP_FW'(cell_hi[FIP_LIMBS-2]) * FIP_FW'(FIP_FOLD);
            assign c_in = FIP_FW'(cell_hi[FIP_LIMBS-1]) * FIP_FW'(FIP_FOLD);
        end
        else if (j == 1)
        begin : g_second
            assign s_lo = FIP_FW'(cell_lo[0]);
            assign s_hi = FIP_FW'(cell_hi[FIP_LIMBS-1]) * FIP_FW'(FIP_FOLD);
            assign c_in = FIP_FW'(cell_hi[0]);
        end
        else
        begin : g_rest
            assign s_lo = FIP_FW'(cell_lo[j-1]);
            assign s_hi = FIP_FW'(cell_hi[j-2]);
            assign c_in = FIP_FW'(cell_hi[j-1]);
        end

        fip_cell u_cell (
            .clk      (clk),
            .ctl      (ctl),
            .a_limb   (a_reg[16*j +: 16]),
            .digit    (b_reg[255:240]),
            .shift_lo (s_lo),
            .shift_hi (s_hi),
            .carry_in (c_in),
            .lo       (cell_lo[j]),
            .hi       (cell_hi[j])
        );

        assign hi_nz[j]            = |cell_hi[j];
        assign norm_val[16*j +: 16] = cell_lo[j];
    end

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        cnt_next   = cnt_reg;
        sq_next    = sq_reg;
        op_next    = op_reg;
        done_next  = 1'b0;
        ctl        = '0;
        load_ops   = 1'b0;
        reload_sq  = 1'b0;
        write_back = 1'b0;
        take_res   = 1'b0;
        sub_en     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_LOAD;
                    pc_next    = '0;
                    op_next    = operand.operation;
                end
            end
            ST_LOAD:
            begin
                load_ops   = 1'b1;
                ctl.clear  = 1'b1;
                cnt_next   = '0;
                sq_next    = step.sq;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                ctl.mul  = 1'b1;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'(FIP_LIMBS - 1))
                begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if (hi_nz != '0)
                begin
                    ctl.norm = 1'b1;
                end
                else if (sq_reg != '0)
                begin
                    sq_next    = sq_reg - 7'd1;
                    reload_sq  = 1'b1;
                    ctl.clear  = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
                else if (pc_reg == PC_INV_END || pc_reg == PC_SQRT_END)
                begin
                    take_res   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_SUB;
                end
                else
                begin
                    write_back = 1'b1;
                    state_next = ST_LOAD;
                    if (pc_reg == PC_BRANCH)
                    begin
                        pc_next = (op_reg == OP_SQRT) ? PC_SQRT : PC_INV;
                    end
                    else
                    begin
                        pc_next = pc_reg + 5'd1;
                    end
                end
            end
            ST_SUB:
            begin
                sub_en   = 1'b1;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd1)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
            cnt_reg   <= '0;
            sq_reg    <= '0;
            op_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            cnt_reg   <= cnt_next;
            sq_reg    <= sq_next;
            op_reg    <= op_next;
            done_reg  <= done_next;
        end
    end

    assign diff = {1'b0, res_reg} - {1'b0, FIP_P};

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem[R_Z] <= {operand.value_w3, operand.value_w2,
                         operand.value_w1, operand.value_w0};
        end
        else if (write_back)
        begin
            mem[step.dst] <= norm_val;
        end

        if (load_ops)
        begin
            a_reg <= mem[step.src_a];
            b_reg <= mem[step.src_b];
        end
        else if (reload_sq)
        begin
            a_reg <= norm_val;
            b_reg <= norm_val;
        end
        else if (ctl.mul)
        begin
            b_reg <= {b_reg[239:0], 16'h0000};
        end

        if (take_res)
        begin
            res_reg <= norm_val;
        end
        else if (sub_en && !diff[256])
        begin
            res_reg <= diff[255:0];
        end
    end

    assign busy             = (state_reg != ST_IDLE);
    assign done             = done_reg;
    assign result.result_w0 = res_reg[63:0];
    assign result.result_w1 = res_reg[127:64];
    assign result.result_w2 = res_reg[191:128];
    assign result.result_w3 = res_reg[254:192];

    `FIP_ASSERT_NOW(a_done_idle, done_reg, state_reg == ST_IDLE, "done outside idle")
    `FIP_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted beat did not start a run")
    `FIP_ASSERT_NOW(a_result_canon, done_reg, res_reg < FIP_P, "result not below p")
    `FIP_ASSERT_NOW(a_mul_no_pc_end, state_reg == ST_MUL, pc_reg <= PC_SQRT_END, "pc out of program")

endmodule

`default_nettype wire
